// ===== src/csl_pkg.sv =====
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types and constants for the character stream lexer: token kinds,
// character codes and the token bundle passed from front end to back end.
// ----------------------------------------------------------------------------
package csl_pkg;

   localparam int MAX_TOKENS  = 3;
   localparam int QUEUE_DEPTH = 4;

   // Token kinds
   localparam logic [4:0] K_LPAREN  = 5'd0;
   localparam logic [4:0] K_RPAREN  = 5'd1;
   localparam logic [4:0] K_LBRACE  = 5'd2;
   localparam logic [4:0] K_RBRACE  = 5'd3;
   localparam logic [4:0] K_COMMA   = 5'd4;
   localparam logic [4:0] K_DOT     = 5'd5;
   localparam logic [4:0] K_MINUS   = 5'd6;
   localparam logic [4:0] K_PLUS    = 5'd7;
   localparam logic [4:0] K_SEMI    = 5'd8;
   localparam logic [4:0] K_STAR    = 5'd9;
   localparam logic [4:0] K_SLASH   = 5'd10;
   localparam logic [4:0] K_BANG    = 5'd11;
   localparam logic [4:0] K_BANG_EQ = 5'd12;
   localparam logic [4:0] K_EQ      = 5'd13;
   localparam logic [4:0] K_EQ_EQ   = 5'd14;
   localparam logic [4:0] K_GT      = 5'd15;
   localparam logic [4:0] K_GT_EQ   = 5'd16;
   localparam logic [4:0] K_LT      = 5'd17;
   localparam logic [4:0] K_LT_EQ   = 5'd18;
   localparam logic [4:0] K_IDENT   = 5'd19;
   localparam logic [4:0] K_STRING  = 5'd20;
   localparam logic [4:0] K_NUMBER  = 5'd21;
   localparam logic [4:0] K_UNKNOWN = 5'd22;
   localparam logic [4:0] K_UNTERM  = 5'd23;

   // Character codes
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start_col;
      logic [15:0] length;
   } tok_type;

   // All tokens of one request share the row count seen on entry
   typedef struct packed {
      logic [1:0]                  count;
      logic [15:0]                 row;
      tok_type [MAX_TOKENS-1:0]    toks;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
                 || (c == CH_UNDER);
   endfunction

endpackage

// ===== src/char_stream_lexer.sv =====
// ----------------------------------------------------------------------------
// char_stream_lexer
// Character stream lexer: one character byte per request in, tokens out.
// ----------------------------------------------------------------------------
// The scanner takes one character per clock while the queue has room and
// builds, combinationally, the bundle of the zero to three tokens that the
// character completes; bundles wait in a four-entry queue and the output side
// hands out one token per clock while the receiver is ready, so characters
// that complete at most one token stream at one per cycle; a character that
// completes two or three tokens holds the output for each in turn, absorbed by
// the queue; each bundle is registered in the queue first. A request with
// req_end_flag set flushes pending tokens and returns the scanner to reset.
module char_stream_lexer #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_end_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_start_col,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_row_number,
   output logic        rsp_last_of_run
);
   import csl_pkg::*;

   bundle_type bundle;
   bundle_type head;
   logic       full;
   logic       empty;
   logic       pop;
   logic       take;

   assign req_ready = !full;
   assign take      = req_valid && req_ready;

   csl_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_char_code),
      .end_flag  (req_end_flag),
      .bundle    (bundle)
   );

   csl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take && (bundle.count != 2'd0)),
      .push_data (bundle),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   csl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_col    (rsp_start_col),
      .rsp_token_length (rsp_token_length),
      .rsp_row_number   (rsp_row_number),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

// ===== src/csl_front.sv =====
// ----------------------------------------------------------------------------
// csl_front
// Scanner state machine: classifies one character per cycle while take is
// high and builds the bundle of tokens that the character completes.
// ----------------------------------------------------------------------------
module csl_front #(
   parameter int POSITION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          char_code,
   input  logic                end_flag,
   output csl_pkg::bundle_type bundle
);
   import csl_pkg::*;

   localparam int P  = POSITION_BITS;
   localparam int EW = (P + 1 > 17) ? P + 1 : 17;

   typedef enum logic [11:0] {
      MODE_IDLE    = 12'b0000_0000_0001,
      MODE_IDENT   = 12'b0000_0000_0010,
      MODE_INT     = 12'b0000_0000_0100,
      MODE_INTDOT  = 12'b0000_0000_1000,
      MODE_FRAC    = 12'b0000_0001_0000,
      MODE_STRING  = 12'b0000_0010_0000,
      MODE_COMMENT = 12'b0000_0100_0000,
      MODE_SLASH   = 12'b0000_1000_0000,
      MODE_BANG    = 12'b0001_0000_0000,
      MODE_EQ      = 12'b0010_0000_0000,
      MODE_GT      = 12'b0100_0000_0000,
      MODE_LT      = 12'b1000_0000_0000
   } mode_type;

   mode_type       mode_ff, mode_in;
   logic           quote_ff, quote_in;
   logic [P-1:0]   start_ff, start_in;
   logic [P-1:0]   pos_ff, pos_in;
   logic [15:0]    line_ff, line_in;

   logic [P-1:0]   pos_m1;
   logic [P-1:0]   span_cur;
   logic [P-1:0]   span_dot;
   logic [15:0]    line_inc;
   logic [1:0]     fl_cnt;
   tok_type        fl_tok0, fl_tok1;
   logic [1:0]     n;
   logic           consumed;
   logic           do_flush;

   function automatic logic [15:0] sat16(input logic [P:0] v);
      logic [EW-1:0] e;
      e = EW'(v);
      sat16 = (e > EW'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
   endfunction

   function automatic logic [P-1:0] span(input logic [P-1:0] a, input logic [P-1:0] b);
      span = (b > a) ? (b - a) : P'(1);
   endfunction

   function automatic tok_type mk(input logic [4:0] kind, input logic [P-1:0] s,
                                  input logic [P:0] len);
      tok_type t;
      t.kind      = kind;
      t.start_col = sat16({1'b0, s});
      t.length    = (len == '0) ? 16'd1 : sat16(len);
      mk = t;
   endfunction

   assign pos_m1   = (pos_ff != '0) ? pos_ff - P'(1) : '0;
   assign span_cur = span(start_ff, pos_ff);
   assign span_dot = span(start_ff, pos_m1);
   assign line_inc = (line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;

   // Tokens left pending by the current mode
   always_comb begin
      fl_cnt  = 2'd0;
      fl_tok0 = '0;
      fl_tok1 = '0;
      case (mode_ff)
         MODE_IDENT: begin
            fl_cnt  = 2'd1;
            fl_tok0 = mk(K_IDENT, start_ff, {1'b0, span_cur});
         end
         MODE_INT, MODE_FRAC: begin
            fl_cnt  = 2'd1;
            fl_tok0 = mk(K_NUMBER, start_ff, {1'b0, span_cur});
         end
         MODE_INTDOT: begin
            fl_cnt  = 2'd2;
            fl_tok0 = mk(K_NUMBER, start_ff, {1'b0, span_dot});
            fl_tok1 = mk(K_DOT, pos_m1, (P+1)'(1));
         end
         MODE_SLASH: begin
            fl_cnt  = 2'd1;
            fl_tok0 = mk(K_SLASH, start_ff, (P+1)'(1));
         end
         MODE_BANG: begin
            fl_cnt  = 2'd1;
            fl_tok0 = mk(K_BANG, start_ff, (P+1)'(1));
         end
         MODE_EQ: begin
            fl_cnt  = 2'd1;
            fl_tok0 = mk(K_EQ, start_ff, (P+1)'(1));
         end
         MODE_GT: begin
            fl_cnt  = 2'd1;
            fl_tok0 = mk(K_GT, start_ff, (P+1)'(1));
         end
         MODE_LT: begin
            fl_cnt  = 2'd1;
            fl_tok0 = mk(K_LT, start_ff, (P+1)'(1));
         end
         default: begin
            fl_cnt = 2'd0;
         end
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      quote_in = quote_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      line_in  = line_ff;
      bundle   = '0;
      n        = 2'd0;
      consumed = 1'b0;
      do_flush = 1'b0;
      bundle.row = line_ff;

      if (end_flag) begin
         if (mode_ff == MODE_STRING) begin
            bundle.toks[0] = mk(K_UNTERM, start_ff, {1'b0, span_cur});
            n = 2'd1;
         end else begin
            bundle.toks[0] = fl_tok0;
            bundle.toks[1] = fl_tok1;
            n = fl_cnt;
         end
         mode_in  = MODE_IDLE;
         quote_in = 1'b0;
         start_in = '0;
         pos_in   = '0;
         line_in  = 16'd1;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_alpha(char_code) || is_digit(char_code)) consumed = 1'b1;
               else do_flush = 1'b1;
            end
            MODE_INT: begin
               if (is_digit(char_code)) begin
                  consumed = 1'b1;
               end else if (char_code == CH_DOT) begin
                  consumed = 1'b1;
                  mode_in  = MODE_INTDOT;
               end else begin
                  do_flush = 1'b1;
               end
            end
            MODE_INTDOT: begin
               if (is_digit(char_code)) begin
                  consumed = 1'b1;
                  mode_in  = MODE_FRAC;
               end else begin
                  do_flush = 1'b1;
               end
            end
            MODE_FRAC: begin
               if (is_digit(char_code)) consumed = 1'b1;
               else do_flush = 1'b1;
            end
            MODE_STRING: begin
               consumed = 1'b1;
               if (char_code == (quote_ff ? CH_SQUOTE : CH_DQUOTE)) begin
                  bundle.toks[0] = mk(K_STRING, start_ff, {1'b0, span_cur} + (P+1)'(1));
                  n       = 2'd1;
                  mode_in = MODE_IDLE;
               end else if (char_code == CH_NL) begin
                  line_in = line_inc;
               end
            end
            MODE_COMMENT: begin
               // newline ends the comment and is then handled as a plain character
               if (char_code != CH_NL) consumed = 1'b1;
               else mode_in = MODE_IDLE;
            end
            MODE_SLASH: begin
               if (char_code == CH_SLASH || char_code == CH_STAR) begin
                  consumed = 1'b1;
                  mode_in  = MODE_COMMENT;
               end else begin
                  do_flush = 1'b1;
               end
            end
            MODE_BANG, MODE_EQ, MODE_GT, MODE_LT: begin
               if (char_code == CH_EQ) begin
                  consumed = 1'b1;
                  bundle.toks[0] = mk(fl_tok0.kind + 5'd1, start_ff, (P+1)'(2));
                  n       = 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1;
               end
            end
            default: begin
               consumed = 1'b0;
            end
         endcase

         if (do_flush) begin
            bundle.toks[0] = fl_tok0;
            bundle.toks[1] = fl_tok1;
            n       = fl_cnt;
            mode_in = MODE_IDLE;
         end

         if (!consumed) begin
            case (char_code)
               CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA, CH_DOT,
               CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR: begin
                  bundle.toks[n].start_col = sat16({1'b0, pos_ff});
                  bundle.toks[n].length    = 16'd1;
                  case (char_code)
                     CH_LPAREN: bundle.toks[n].kind = K_LPAREN;
                     CH_RPAREN: bundle.toks[n].kind = K_RPAREN;
                     CH_LBRACE: bundle.toks[n].kind = K_LBRACE;
                     CH_RBRACE: bundle.toks[n].kind = K_RBRACE;
                     CH_COMMA:  bundle.toks[n].kind = K_COMMA;
                     CH_DOT:    bundle.toks[n].kind = K_DOT;
                     CH_MINUS:  bundle.toks[n].kind = K_MINUS;
                     CH_PLUS:   bundle.toks[n].kind = K_PLUS;
                     CH_SEMI:   bundle.toks[n].kind = K_SEMI;
                     default:   bundle.toks[n].kind = K_STAR;
                  endcase
                  n = n + 2'd1;
               end
               CH_SLASH: begin
                  mode_in  = MODE_SLASH;
                  start_in = pos_ff;
               end
               CH_BANG: begin
                  mode_in  = MODE_BANG;
                  start_in = pos_ff;
               end
               CH_EQ: begin
                  mode_in  = MODE_EQ;
                  start_in = pos_ff;
               end
               CH_GT: begin
                  mode_in  = MODE_GT;
                  start_in = pos_ff;
               end
               CH_LT: begin
                  mode_in  = MODE_LT;
                  start_in = pos_ff;
               end
               CH_SPACE, CH_TAB, CH_CR: begin
                  consumed = 1'b0;
               end
               CH_NL: begin
                  line_in = line_inc;
               end
               CH_DQUOTE, CH_SQUOTE: begin
                  quote_in = (char_code == CH_SQUOTE);
                  mode_in  = MODE_STRING;
                  start_in = pos_ff;
               end
               default: begin
                  if (is_digit(char_code)) begin
                     mode_in  = MODE_INT;
                     start_in = pos_ff;
                  end else if (is_alpha(char_code)) begin
                     mode_in  = MODE_IDENT;
                     start_in = pos_ff;
                  end else begin
                     bundle.toks[n] = mk(K_UNKNOWN, pos_ff, (P+1)'(1));
                     n = n + 2'd1;
                  end
               end
            endcase
         end

         // position sticks at all ones
         if (pos_ff != '1) pos_in = pos_ff + P'(1);
      end

      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         quote_ff <= 1'b0;
         start_ff <= '0;
         pos_ff   <= '0;
         line_ff  <= 16'd1;
      end else if (take) begin
         mode_ff  <= mode_in;
         quote_ff <= quote_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         line_ff  <= line_in;
      end
   end

endmodule

// ===== src/csl_queue.sv =====
// ----------------------------------------------------------------------------
// csl_queue
// Short queue of token bundles between the scanner and the output side.
// ----------------------------------------------------------------------------
module csl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csl_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output csl_pkg::bundle_type head
);
   import csl_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   bundle_type           entry_ff [QUEUE_DEPTH];
   logic [AW-1:0]        wr_ff, wr_in;
   logic [AW-1:0]        rd_ff, rd_in;
   logic [AW:0]          cnt_ff, cnt_in;
   logic                 do_push;
   logic                 do_pop;

   assign full    = (cnt_ff == (AW+1)'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + AW'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + (AW+1)'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - (AW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_data;
   end

endmodule

// ===== src/csl_back.sv =====
// ----------------------------------------------------------------------------
// csl_back
// Output side: walks the tokens of the head bundle, one per accepted result.
// ----------------------------------------------------------------------------
module csl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  csl_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [4:0]          rsp_token_kind,
   output logic [15:0]         rsp_start_col,
   output logic [15:0]         rsp_token_length,
   output logic [15:0]         rsp_row_number,
   output logic                rsp_last_of_run
);
   import csl_pkg::*;

   logic [1:0] sub_ff, sub_in;
   logic       last;
   tok_type    cur;

   assign cur  = head.toks[sub_ff];
   assign last = (sub_ff == head.count - 2'd1);

   assign rsp_valid        = !empty;
   assign rsp_token_kind   = cur.kind;
   assign rsp_start_col    = cur.start_col;
   assign rsp_token_length = cur.length;
   assign rsp_row_number   = head.row;
   assign rsp_last_of_run  = last;

   // drop the bundle once its last token is taken
   assign pop = rsp_valid && rsp_ready && last;

   always_comb begin
      sub_in = sub_ff;
      if (rsp_valid && rsp_ready) sub_in = last ? 2'd0 : sub_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 2'd0;
      end else begin
         sub_ff <= sub_in;
      end
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for char_stream_lexer. A token tracker follows the
// scanner state for every accepted character request and queues the tokens
// it should produce; each token the block hands out is compared field by
// field with the oldest queued one. Stimulus runs short directed lists
// and random well-formed token text mixed with noise, under three patterns
// of sender and receiver stalls, the last with none.
// ----------------------------------------------------------------------------
module tb;
   import csl_pkg::*;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_INT, SCAN_POINT, SCAN_FRACTION, SCAN_QUOTED,
      SCAN_COMMENT, SCAN_SLASH, SCAN_BANG, SCAN_EQ, SCAN_GT, SCAN_LT
   } scan_mode_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start_col;
      logic [15:0] length;
      logic [15:0] row;
      logic        last;
   } token_rec_type;

   class token_tracker;
      scan_mode_type mode;
      logic          quote_single;
      int            tok_start;
      int            pos;
      int            rows;
      int            errors;
      token_rec_type char_tokens[$];
      token_rec_type expected_tokens[$];

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         mode = SCAN_IDLE;
         quote_single = 1'b0;
         tok_start = 0;
         pos = 0;
         rows = 1;
      endfunction

      function int pending_count();
         return expected_tokens.size();
      endfunction

      function bit decimal_digit(logic [7:0] c);
         return c >= 8'h30 && c <= 8'h39;
      endfunction

      function bit word_start(logic [7:0] c);
         return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
      endfunction

      function int span(int a, int b);
         return (b > a) ? b - a : 1;
      endfunction

      function logic [4:0] op_kind(scan_mode_type m, bit pair);
         case (m)
            SCAN_BANG: return pair ? K_BANG_EQ : K_BANG;
            SCAN_EQ:   return pair ? K_EQ_EQ : K_EQ;
            SCAN_GT:   return pair ? K_GT_EQ : K_GT;
            default:   return pair ? K_LT_EQ : K_LT;
         endcase
      endfunction

      function void push_token(logic [4:0] kind, int start, int len);
         token_rec_type t;
         if (char_tokens.size() >= MAX_TOKENS) return;
         if (len == 0) len = 1;
         if (len > 65535) len = 65535;
         if (start > 65535) start = 65535;
         t.kind = kind;
         t.start_col = start[15:0];
         t.length = len[15:0];
         t.row = rows[15:0];
         t.last = 1'b0;
         char_tokens.insert(char_tokens.size(), t);
      endfunction

      function void open_token(scan_mode_type m);
         mode = m;
         tok_start = pos;
      endfunction

      // Emit whatever tokens are waiting for lookahead, ending just before pos.
      function void flush_pending();
         int point_pos;
         point_pos = (pos > 0) ? pos - 1 : 0;
         case (mode)
            SCAN_WORD: push_token(K_IDENT, tok_start, span(tok_start, pos));
            SCAN_INT, SCAN_FRACTION: push_token(K_NUMBER, tok_start, span(tok_start, pos));
            SCAN_POINT: begin
               push_token(K_NUMBER, tok_start, span(tok_start, point_pos));
               push_token(K_DOT, point_pos, 1);
            end
            SCAN_SLASH: push_token(K_SLASH, tok_start, 1);
            SCAN_BANG, SCAN_EQ, SCAN_GT, SCAN_LT: push_token(op_kind(mode, 1'b0), tok_start, 1);
            default: ;
         endcase
         mode = SCAN_IDLE;
      endfunction

      // Return 1 when the open token swallows the character.
      function bit mode_takes(logic [7:0] c);
         case (mode)
            SCAN_IDLE: return 1'b0;
            SCAN_WORD: if (word_start(c) || decimal_digit(c)) return 1'b1;
            SCAN_INT: begin
               if (decimal_digit(c)) return 1'b1;
               if (c == CH_DOT) begin
                  mode = SCAN_POINT;
                  return 1'b1;
               end
            end
            SCAN_POINT: begin
               if (decimal_digit(c)) begin
                  mode = SCAN_FRACTION;
                  return 1'b1;
               end
            end
            SCAN_FRACTION: if (decimal_digit(c)) return 1'b1;
            SCAN_QUOTED: begin
               if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                  push_token(K_STRING, tok_start, span(tok_start, pos) + 1);
                  mode = SCAN_IDLE;
               end else if (c == CH_NL && rows < 65535) begin
                  rows++;
               end
               return 1'b1;
            end
            SCAN_COMMENT: begin
               if (c != CH_NL) return 1'b1;
               // the newline itself still counts a row in idle handling
               mode = SCAN_IDLE;
               return 1'b0;
            end
            SCAN_SLASH: begin
               if (c == CH_SLASH || c == CH_STAR) begin
                  mode = SCAN_COMMENT;
                  return 1'b1;
               end
            end
            default: begin
               if (c == CH_EQ) begin
                  push_token(op_kind(mode, 1'b1), tok_start, 2);
                  mode = SCAN_IDLE;
                  return 1'b1;
               end
            end
         endcase
         flush_pending();
         return 1'b0;
      endfunction

      function void idle_char(logic [7:0] c);
         case (c)
            CH_LPAREN: push_token(K_LPAREN, pos, 1);
            CH_RPAREN: push_token(K_RPAREN, pos, 1);
            CH_LBRACE: push_token(K_LBRACE, pos, 1);
            CH_RBRACE: push_token(K_RBRACE, pos, 1);
            CH_COMMA:  push_token(K_COMMA, pos, 1);
            CH_DOT:    push_token(K_DOT, pos, 1);
            CH_MINUS:  push_token(K_MINUS, pos, 1);
            CH_PLUS:   push_token(K_PLUS, pos, 1);
            CH_SEMI:   push_token(K_SEMI, pos, 1);
            CH_STAR:   push_token(K_STAR, pos, 1);
            CH_SLASH:  open_token(SCAN_SLASH);
            CH_BANG:   open_token(SCAN_BANG);
            CH_EQ:     open_token(SCAN_EQ);
            CH_GT:     open_token(SCAN_GT);
            CH_LT:     open_token(SCAN_LT);
            CH_SPACE, CH_TAB, CH_CR: ;
            CH_NL:     if (rows < 65535) rows++;
            CH_DQUOTE, CH_SQUOTE: begin
               quote_single = (c == CH_SQUOTE);
               open_token(SCAN_QUOTED);
            end
            default: begin
               if (decimal_digit(c)) open_token(SCAN_INT);
               else if (word_start(c)) open_token(SCAN_WORD);
               else push_token(K_UNKNOWN, pos, 1);
            end
         endcase
      endfunction

      function void note_char(logic [7:0] c, logic end_mark);
         char_tokens.delete();
         if (end_mark) begin
            if (mode == SCAN_QUOTED) push_token(K_UNTERM, tok_start, span(tok_start, pos));
            else flush_pending();
            clear_state();
         end else begin
            if (!mode_takes(c)) idle_char(c);
            if (pos < 65535) pos++;
         end
         if (char_tokens.size() > 0) char_tokens[char_tokens.size() - 1].last = 1'b1;
         foreach (char_tokens[i]) expected_tokens.insert(expected_tokens.size(), char_tokens[i]);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("mismatch: %s", msg);
      endtask

      task check_token(logic [4:0] kind, logic [15:0] start, logic [15:0] len,
                       logic [15:0] row, logic last);
         token_rec_type want;
         if (expected_tokens.size() == 0) begin
            report($sformatf("token kind %0d col %0d arrived with none expected", kind, start));
            return;
         end
         want = expected_tokens.pop_front();
         if (kind !== want.kind)
            report($sformatf("kind %0d, expected %0d (col %0d)", kind, want.kind, want.start_col));
         if (start !== want.start_col)
            report($sformatf("start_col %0d, expected %0d", start, want.start_col));
         if (len !== want.length)
            report($sformatf("token_length %0d, expected %0d (col %0d)", len, want.length,
                             want.start_col));
         if (row !== want.row)
            report($sformatf("row_number %0d, expected %0d (col %0d)", row, want.row,
                             want.start_col));
         if (last !== want.last)
            report($sformatf("last_of_run %0b, expected %0b (col %0d)", last, want.last,
                             want.start_col));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_end_flag = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_start_col;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_row_number;
   logic        rsp_last_of_run;

   token_tracker tracker = new();
   int send_idle_pct = 10;
   int recv_idle_pct = 82;
   int sent_count = 0;

   char_stream_lexer i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .req_end_flag(req_end_flag),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_token_kind(rsp_token_kind),
      .rsp_start_col(rsp_start_col),
      .rsp_token_length(rsp_token_length),
      .rsp_row_number(rsp_row_number),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always #6 clock = ~clock;

   initial begin
      #24_000_000;
      $display("FAIL char_stream_lexer");
      $finish;
   end

   // Note requests and check tokens from values sampled at the same edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_valid && req_ready) tracker.note_char(req_char_code, req_end_flag);
            if (rsp_valid && rsp_ready)
               tracker.check_token(rsp_token_kind, rsp_start_col, rsp_token_length,
                                   rsp_row_number, rsp_last_of_run);
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_char(input logic [7:0] c, input logic end_mark);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      req_end_flag <= end_mark;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   function automatic logic [7:0] pick_char(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // Hold off the sender until every expected token has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_fragment();
      string letters;
      string digits;
      logic [7:0] quote;
      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
      digits = "0123456789";
      case ($urandom_range(0, 15))
         0, 1, 2: begin
            send_char(pick_char(letters), 1'b0);
            repeat ($urandom_range(0, 5)) send_char(pick_char({letters, digits}), 1'b0);
         end
         3, 4: begin
            repeat ($urandom_range(1, 4)) send_char(pick_char(digits), 1'b0);
            if ($urandom_range(0, 1)) begin
               send_char(CH_DOT, 1'b0);
               repeat ($urandom_range(0, 3)) send_char(pick_char(digits), 1'b0);
            end
         end
         5, 6: begin
            quote = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            send_char(quote, 1'b0);
            repeat ($urandom_range(0, 6))
               send_char(($urandom_range(0, 7) == 0) ? CH_NL : 8'($urandom_range(32, 126)),
                         1'b0);
            // leave some strings open so the end request closes them
            if ($urandom_range(0, 99) < 85) send_char(quote, 1'b0);
         end
         7, 8: begin
            send_char(pick_char("!=<>"), 1'b0);
            if ($urandom_range(0, 1)) send_char(CH_EQ, 1'b0);
         end
         9, 10: send_char(pick_char("(){},.-+;*/"), 1'b0);
         11: send_char(pick_char(" \t\r"), 1'b0);
         12: send_char(CH_NL, 1'b0);
         13: begin
            send_char(CH_SLASH, 1'b0);
            send_char($urandom_range(0, 1) ? CH_SLASH : CH_STAR, 1'b0);
            repeat ($urandom_range(0, 5)) send_char(8'($urandom_range(0, 255)), 1'b0);
            send_char(CH_NL, 1'b0);
         end
         14: send_char(8'($urandom_range(0, 255)), 1'b0);
         default: send_char(8'($urandom_range(0, 255)), 1'b1);
      endcase
   endtask

   task automatic run_random(input int count);
      int first;
      first = sent_count;
      while (sent_count - first < count) send_random_fragment();
      send_char(8'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pending tokens, two-char operators, point without fraction, odd bytes
      send_text("x_9==");
      send_text("12.(");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("'a\"");
      send_char(8'h5A, 1'b1);
      send_text("//*");
      send_char(8'hA5, 1'b1);
      send_text("3.5<");
      send_char(8'h00, 1'b1);
      run_random(48);
      wait_drained();

      send_idle_pct = 82;
      recv_idle_pct = 10;
      run_random(48);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_text("ab(\"x\"=");
      send_char(8'h00, 1'b1);
      run_random(48);

      wait_drained();
      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("PASS char_stream_lexer");
      end else begin
         $display("FAIL char_stream_lexer");
      end
      $finish;
   end
endmodule
